// ===== rtl/point_set_centroid_rotation_assert.svh =====
// assertion macros shared by the checker
`ifndef POINT_SET_CENTROID_ROTATION_ASSERT_SVH
`define POINT_SET_CENTROID_ROTATION_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define PSCR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pscr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscr_pkg
// types and constants for the point set centroid rotation block
// ----------------------------------------------------------------------------
package pscr_pkg;
  localparam int CoordW = 24;
  localparam int DiffW  = 25;
  localparam int SumW   = 28;
  localparam int TrigW  = 16;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic signed [TrigW-1:0]  trig_t;

  localparam coord_t CoordMax = 24'sh7fffff;
  localparam coord_t CoordMin = -24'sh800000;
  localparam coord_t ZCeiling = 24'sd6553600;
  localparam trig_t  TrigOne  = 16'sd16384;

  localparam logic [2:0] RegCosX = 3'd0;
  localparam logic [2:0] RegSinX = 3'd1;
  localparam logic [2:0] RegCosY = 3'd2;
  localparam logic [2:0] RegSinY = 3'd3;
  localparam logic [2:0] RegCosZ = 3'd4;
  localparam logic [2:0] RegSinZ = 3'd5;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_READ,
    ST_ROT,
    ST_OUT
  } state_t;

  // rotation step selector for the shared datapath
  typedef enum logic [1:0] {
    STEP_LOAD,
    STEP_X,
    STEP_Y,
    STEP_Z
  } step_t;

  // saturate a wide signed value to a coordinate
  function automatic coord_t sat_coord(input logic signed [39:0] v);
    if (v > 40'(signed'(CoordMax))) return CoordMax;
    if (v < 40'(signed'(CoordMin))) return CoordMin;
    return v[CoordW-1:0];
  endfunction

  // round(v / 2^14), ties toward +inf, saturated
  function automatic coord_t q14(input logic signed [42:0] v);
    logic signed [42:0] w;
    w = v + 43'sd8192;
    return sat_coord(40'(w >>> 14));
  endfunction
endpackage

// ===== rtl/pscr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscr_in_if / pscr_out_if
// valid/ready channels carrying input points and rotated results
// ----------------------------------------------------------------------------
interface pscr_in_if;
  import pscr_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  logic   last_point;
  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface pscr_out_if;
  import pscr_pkg::*;
  logic   valid;
  logic   ready;
  coord_t rotated_x;
  coord_t rotated_y;
  coord_t rotated_z;
  coord_t lowest_x;
  coord_t lowest_y;
  coord_t lowest_z;
  logic   final_result;
  modport source (output valid, rotated_x, rotated_y, rotated_z, lowest_x, lowest_y,
                  lowest_z, final_result, input ready);
  modport sink   (input valid, rotated_x, rotated_y, rotated_z, lowest_x, lowest_y,
                  lowest_z, final_result, output ready);
endinterface

// ===== rtl/pscr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscr_ram
// generic single-port write, single-port read ram with registered read
// ----------------------------------------------------------------------------
module pscr_ram #(
  parameter int Width = 72,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/pscr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscr_div
// restoring divider, one quotient bit a cycle, rounds magnitude to nearest
// ----------------------------------------------------------------------------
module pscr_div #(
  parameter int CntW = 9
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  pscr_pkg::sum_t          dividend,
  input  logic [CntW-1:0]         divisor,
  output logic                    done,
  output pscr_pkg::coord_t        quotient
);
  import pscr_pkg::*;

  localparam int MagW = SumW + 1;
  localparam int BitW = $clog2(MagW + 1);

  logic [MagW-1:0] num;
  logic [MagW-1:0] quo;
  logic [CntW:0]   rem;
  logic [BitW-1:0] bits;
  logic            neg;
  logic            busy;
  logic [CntW:0]   trial;
  logic signed [MagW-1:0] dvd_ext;
  logic [MagW-1:0] mag_in;
  logic signed [MagW+1:0] signed_q;

  always_comb begin
    dvd_ext  = MagW'(dividend);
    mag_in   = (dividend[SumW-1] ? -dvd_ext : dvd_ext) + MagW'(divisor >> 1);
    trial    = {rem[CntW-1:0], num[MagW-1]};
    signed_q = neg ? -(MagW + 2)'(quo) : (MagW + 2)'(quo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bits <= BitW'(MagW);
        num  <= mag_in;
        rem  <= '0;
        quo  <= '0;
        neg  <= dividend[SumW-1];
      end else if (busy) begin
        num <= num << 1;
        if (trial >= (CntW + 1)'(divisor)) begin
          rem <= trial - (CntW + 1)'(divisor);
          quo <= {quo[MagW-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[MagW-2:0], 1'b0};
        end
        bits <= bits - 1'b1;
        if (bits == BitW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = sat_coord(40'(signed_q));
endmodule

// ===== rtl/point_set_centroid_rotation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_set_centroid_rotation
// loads a point set into ram, then rotates every point about the centroid
// ----------------------------------------------------------------------------
// channel   | modport | carries
// in_pt     | sink    | point_x/y/z, last_point
// out_rot   | source  | rotated_x/y/z, lowest_x/y/z, final_result
// apb       | slave   | six q1.14 sine/cosine registers
//
// a point is accepted each cycle while loading; points past MAX_POINTS are dropped.
// the last point starts three serial divisions for the centroid, then each
// stored point passes through ram read, difference load, x, y and z rotation
// in the shared multiplier datapath, and output handoff.
// input ready is low from the last point until the final result is registered.
// a stalled output register holds and stalls the walk; rst is synchronous.
// ----------------------------------------------------------------------------
module point_set_centroid_rotation #(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  pscr_in_if.sink     in_pt,
  pscr_out_if.source  out_rot,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pscr_pkg::*;

  localparam int AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CntW  = $clog2(MAX_POINTS + 1);
  localparam int RamW  = 3 * CoordW;
  localparam logic signed [SumW:0] SumMax = (SumW + 1)'(2 ** (SumW - 1) - 1);
  localparam logic signed [SumW:0] SumMin = -(SumW + 1)'(2 ** (SumW - 1));

  trig_t cx_r, sx_r, cy_r, sy_r, cz_r, sz_r;
  state_t state, state_next;
  step_t  step;

  logic [CntW-1:0] count;
  logic [CntW-1:0] rd_idx;
  sum_t  sum_x, sum_y, sum_z;
  coord_t cen_x, cen_y, cen_z;
  logic [1:0] div_sel;
  logic  div_run;
  logic  div_start, div_done;
  sum_t  div_in;
  coord_t div_q;

  logic [RamW-1:0] ram_rd;
  logic            ram_we;
  diff_t vx, vy, vz;
  coord_t low_x, low_y, low_z;

  logic   ov;
  logic   out_load;
  coord_t o_x, o_y, o_z, o_lx, o_ly, o_lz;
  logic   o_fin;

  // configuration
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cx_r <= TrigOne; sx_r <= '0;
      cy_r <= TrigOne; sy_r <= '0;
      cz_r <= TrigOne; sz_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        RegCosX: cx_r <= pwdata[TrigW-1:0];
        RegSinX: sx_r <= pwdata[TrigW-1:0];
        RegCosY: cy_r <= pwdata[TrigW-1:0];
        RegSinY: sy_r <= pwdata[TrigW-1:0];
        RegCosZ: cz_r <= pwdata[TrigW-1:0];
        RegSinZ: sz_r <= pwdata[TrigW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegCosX: prdata = 32'(cx_r);
      RegSinX: prdata = 32'(sx_r);
      RegCosY: prdata = 32'(cy_r);
      RegSinY: prdata = 32'(sy_r);
      RegCosZ: prdata = 32'(cz_r);
      RegSinZ: prdata = 32'(sz_r);
      default: prdata = '0;
    endcase
  end

  // point store
  logic in_fire;
  logic has_room;
  assign in_pt.ready = (state == ST_LOAD);
  assign in_fire  = in_pt.valid && in_pt.ready;
  assign has_room = count < CntW'(MAX_POINTS);
  assign ram_we   = in_fire && has_room;

  pscr_ram #(.Width(RamW), .Depth(MAX_POINTS), .AddrW(AddrW)) u_pts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AddrW-1:0]),
    .wdata ({in_pt.point_x, in_pt.point_y, in_pt.point_z}),
    .raddr (rd_idx[AddrW-1:0]),
    .rdata (ram_rd)
  );

  function automatic sum_t sum_add(input sum_t s, input coord_t p);
    logic signed [SumW:0] t;
    t = (SumW + 1)'(s) + (SumW + 1)'(p);
    if (t > SumMax) return SumMax[SumW-1:0];
    if (t < SumMin) return SumMin[SumW-1:0];
    return t[SumW-1:0];
  endfunction

  // centroid divider
  always_comb begin
    case (div_sel)
      2'd0:    div_in = sum_x;
      2'd1:    div_in = sum_y;
      default: div_in = sum_z;
    endcase
  end

  pscr_div #(.CntW(CntW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_q)
  );

  // shared rotation datapath: one axis a cycle
  trig_t  c_sel, s_sel;
  diff_t  a_sel, b_sel;
  logic signed [42:0] p_ac, p_bs, p_as, p_bc;
  logic signed [42:0] p_one, p_two;
  coord_t r_one, r_two;
  logic signed [DiffW:0] fx, fy, fz;

  always_comb begin
    c_sel = cx_r; s_sel = sx_r; a_sel = vy; b_sel = vz;
    case (step)
      STEP_Y: begin c_sel = cy_r; s_sel = sy_r; a_sel = vx; b_sel = vz; end
      STEP_Z: begin c_sel = cz_r; s_sel = sz_r; a_sel = vx; b_sel = vy; end
      default: ;
    endcase
    p_ac = 43'(a_sel) * 43'(c_sel);
    p_bs = 43'(b_sel) * 43'(s_sel);
    p_as = 43'(a_sel) * 43'(s_sel);
    p_bc = 43'(b_sel) * 43'(c_sel);
    // first: a*c + b*s (y step uses a*c - b*s); second: -a*s + b*c (y: a*s + b*c)
    if (step == STEP_Y) begin
      p_one = p_ac - p_bs;
      p_two = p_as + p_bc;
    end else begin
      p_one = p_ac + p_bs;
      p_two = p_bc - p_as;
    end
    r_one = q14(p_one);
    r_two = q14(p_two);
    fx = (DiffW + 1)'(vx) + (DiffW + 1)'(cen_x);
    fy = (DiffW + 1)'(vy) + (DiffW + 1)'(cen_y);
    fz = (DiffW + 1)'(vz) + (DiffW + 1)'(cen_z);
  end

  coord_t fin_x, fin_y, fin_z;
  assign fin_x = sat_coord(40'(fx));
  assign fin_y = sat_coord(40'(fy));
  assign fin_z = sat_coord(40'(fz));

  logic is_final_pt;
  assign is_final_pt = (rd_idx + 1'b1) == count;

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_LOAD: if (in_fire && in_pt.last_point) begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        // sums include the last point by now
        if (!div_run) begin
          div_start = 1'b1;
        end else if (div_done && div_sel == 2'd2) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_ROT;
      ST_ROT:  if (step == STEP_Z) state_next = ST_OUT;
      ST_OUT:  if (!ov || out_rot.ready) begin
        out_load   = 1'b1;
        state_next = is_final_pt ? ST_LOAD : ST_READ;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum_x <= '0; sum_y <= '0; sum_z <= '0;
      div_sel <= '0;
      div_run <= 1'b0;
      rd_idx <= '0;
      step <= STEP_LOAD;
      low_x <= '0; low_y <= '0; low_z <= ZCeiling;
    end else begin
      case (state)
        ST_LOAD: begin
          if (ram_we) begin
            count <= count + 1'b1;
            sum_x <= sum_add(sum_x, in_pt.point_x);
            sum_y <= sum_add(sum_y, in_pt.point_y);
            sum_z <= sum_add(sum_z, in_pt.point_z);
          end
          div_sel <= '0;
          div_run <= 1'b0;
          rd_idx  <= '0;
          low_x <= '0; low_y <= '0; low_z <= ZCeiling;
        end
        ST_DIV: begin
          if (div_start) begin
            div_run <= 1'b1;
          end else if (div_done) begin
            case (div_sel)
              2'd0:    cen_x <= div_q;
              2'd1:    cen_y <= div_q;
              default: cen_z <= div_q;
            endcase
            div_sel <= div_sel + 1'b1;
            div_run <= 1'b0;
          end
        end
        ST_READ: step <= STEP_LOAD;
        ST_ROT: begin
          case (step)
            STEP_LOAD: begin
              vx <= DiffW'(coord_t'(ram_rd[3*CoordW-1:2*CoordW])) - DiffW'(cen_x);
              vy <= DiffW'(coord_t'(ram_rd[2*CoordW-1:CoordW])) - DiffW'(cen_y);
              vz <= DiffW'(coord_t'(ram_rd[CoordW-1:0])) - DiffW'(cen_z);
              step <= STEP_X;
            end
            STEP_X: begin
              vy <= DiffW'(r_one); vz <= DiffW'(r_two);
              step <= STEP_Y;
            end
            STEP_Y: begin
              vx <= DiffW'(r_one); vz <= DiffW'(r_two);
              step <= STEP_Z;
            end
            default: begin
              vx <= DiffW'(r_one); vy <= DiffW'(r_two);
              step <= STEP_LOAD;
            end
          endcase
        end
        ST_OUT: if (out_load) begin
          if (low_z >= fin_z) begin
            low_x <= fin_x; low_y <= fin_y; low_z <= fin_z;
          end
          if (is_final_pt) begin
            count <= '0;
            sum_x <= '0; sum_y <= '0; sum_z <= '0;
          end
          rd_idx <= rd_idx + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else begin
      ov <= out_load || (ov && !out_rot.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_x   <= fin_x; o_y <= fin_y; o_z <= fin_z;
      o_fin <= is_final_pt;
      if (is_final_pt) begin
        if (low_z >= fin_z) begin
          o_lx <= fin_x; o_ly <= fin_y; o_lz <= fin_z;
        end else begin
          o_lx <= low_x; o_ly <= low_y; o_lz <= low_z;
        end
      end else begin
        o_lx <= '0; o_ly <= '0; o_lz <= '0;
      end
    end
  end

  assign out_rot.valid        = ov;
  assign out_rot.rotated_x    = o_x;
  assign out_rot.rotated_y    = o_y;
  assign out_rot.rotated_z    = o_z;
  assign out_rot.lowest_x     = o_lx;
  assign out_rot.lowest_y     = o_ly;
  assign out_rot.lowest_z     = o_lz;
  assign out_rot.final_result = o_fin;
endmodule

// ===== rtl/pscr_checker.sv =====
`timescale 1ns / 1ps
`include "point_set_centroid_rotation_assert.svh"
// ----------------------------------------------------------------------------
// pscr_checker
// port-level checks for the point set centroid rotation block
// ----------------------------------------------------------------------------
module pscr_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_final,
  input logic pready
);
  // input is closed once a set's last point has been taken
  `PSCR_ASSERT_NEXT(a_last_closes, in_valid && in_ready && in_last, !in_ready, "input open after last")
  // no result but the final one shown while points are still being loaded
  `PSCR_ASSERT_IMPL(a_no_out_while_loading, in_ready, !out_valid || out_final, "result during load")
  // output stalled holds
  `PSCR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output dropped under stall")
  `PSCR_ASSERT_IMPL(a_pready, 1'b1, pready, "pready low")
endmodule

bind point_set_centroid_rotation pscr_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_pt.valid),
  .in_ready  (in_pt.ready),
  .in_last   (in_pt.last_point),
  .out_valid (out_rot.valid),
  .out_ready (out_rot.ready),
  .out_final (out_rot.final_result),
  .pready    (pready)
);

// ===== tb/tb_point_set_centroid_rotation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_set_centroid_rotation
// drives point sets through the block under random sine/cosine settings and
// checks every rotated point and the lowest-z fields against a local predictor
// ----------------------------------------------------------------------------
module tb_point_set_centroid_rotation;
  import pscr_pkg::*;

  typedef struct packed {
    coord_t rx;
    coord_t ry;
    coord_t rz;
    coord_t lx;
    coord_t ly;
    coord_t lz;
    logic   fin;
  } rot_result_t;

  class rotation_scoreboard;
    longint trig[6];
    longint px[16], py[16], pz[16];
    int     count;
    longint sx, sy, sz;
    rot_result_t pending[$];
    int     errors;

    function new();
      trig[0] = 16384; trig[1] = 0; trig[2] = 16384;
      trig[3] = 0;     trig[4] = 16384; trig[5] = 0;
      count = 0; sx = 0; sy = 0; sz = 0; errors = 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint shift14(longint v);
      longint w, r;
      w = v + 8192;
      if (w >= 0) r = w >>> 14;
      else r = -((-w + 16383) >>> 14);
      return clip(r, -8388608, 8388607);
    endfunction

    function longint mean(longint s, int n);
      longint m, q;
      m = s < 0 ? -s : s;
      q = (m + n / 2) / n;
      return s < 0 ? -q : q;
    endfunction

    function void set_trig(int idx, logic [15:0] v);
      trig[idx] = longint'($signed(v));
    endfunction

    function void note_point(coord_t x, coord_t y, coord_t z, logic last);
      longint cx, cy, cz, a, b, c, t, lx, ly, lz;
      longint ox[16], oy[16], oz[16];
      rot_result_t r;
      if (count < 16) begin
        px[count] = x; py[count] = y; pz[count] = z;
        sx = clip(sx + x, -134217728, 134217727);
        sy = clip(sy + y, -134217728, 134217727);
        sz = clip(sz + z, -134217728, 134217727);
        count++;
      end
      if (!last) return;
      cx = clip(mean(sx, count), -8388608, 8388607);
      cy = clip(mean(sy, count), -8388608, 8388607);
      cz = clip(mean(sz, count), -8388608, 8388607);
      lx = 0; ly = 0; lz = 6553600;
      for (int k = 0; k < count; k++) begin
        a = px[k] - cx; b = py[k] - cy; c = pz[k] - cz;
        t = b;
        b = shift14(b * trig[0] + c * trig[1]);
        c = shift14(-t * trig[1] + c * trig[0]);
        t = a;
        a = shift14(a * trig[2] - c * trig[3]);
        c = shift14(t * trig[3] + c * trig[2]);
        t = a;
        a = shift14(a * trig[4] + b * trig[5]);
        b = shift14(-t * trig[5] + b * trig[4]);
        ox[k] = clip(a + cx, -8388608, 8388607);
        oy[k] = clip(b + cy, -8388608, 8388607);
        oz[k] = clip(c + cz, -8388608, 8388607);
        if (lz >= oz[k]) begin
          lx = ox[k]; ly = oy[k]; lz = oz[k];
        end
      end
      for (int k = 0; k < count; k++) begin
        r.rx = coord_t'(ox[k]); r.ry = coord_t'(oy[k]); r.rz = coord_t'(oz[k]);
        r.fin = (k == count - 1);
        r.lx = r.fin ? coord_t'(lx) : '0;
        r.ly = r.fin ? coord_t'(ly) : '0;
        r.lz = r.fin ? coord_t'(lz) : '0;
        pending.push_back(r);
      end
      count = 0; sx = 0; sy = 0; sz = 0;
    endfunction

    function void check_result(rot_result_t got);
      rot_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected rx=%0d ry=%0d rz=%0d lx=%0d ly=%0d lz=%0d fin=%0b",
                 $time, want.rx, want.ry, want.rz, want.lx, want.ly, want.lz, want.fin);
        $display("%0t:          actual   rx=%0d ry=%0d rz=%0d lx=%0d ly=%0d lz=%0d fin=%0b",
                 $time, got.rx, got.ry, got.rz, got.lx, got.ly, got.lz, got.fin);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        rx_noidle;
  bit          hold_req;
  int          hold_cnt = 0;
  bit          noidle;

  pscr_in_if  in_pt ();
  pscr_out_if out_rot ();

  point_set_centroid_rotation DUT (
    .clk(clk), .rst(rst), .in_pt(in_pt.sink), .out_rot(out_rot.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rotation_scoreboard board = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("** point_set_centroid_rotation: FAILED **");
    $finish;
  end

  // result side: random stalls, one long hold-off
  always @(posedge clk) begin
    if (!rst && out_rot.valid && out_rot.ready)
      board.check_result({out_rot.rotated_x, out_rot.rotated_y, out_rot.rotated_z,
                          out_rot.lowest_x, out_rot.lowest_y, out_rot.lowest_z,
                          out_rot.final_result});
  end

  initial begin
    out_rot.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_cnt < 400) begin
        hold_cnt++;
        out_rot.ready <= 1'b0;
      end else begin
        out_rot.ready <= rx_noidle || ($urandom_range(99) >= 17);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {{16{v[15]}}, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_trig(idx, v);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                            input logic last);
    @(negedge clk);
    while (!noidle && $urandom_range(99) < 17) begin
      in_pt.valid <= 1'b0;
      @(negedge clk);
    end
    in_pt.valid <= 1'b1;
    in_pt.point_x <= x; in_pt.point_y <= y; in_pt.point_z <= z;
    in_pt.last_point <= last;
    @(posedge clk);
    while (!in_pt.ready) @(posedge clk);
    board.note_point(x, y, z, last);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    in_pt.valid <= 1'b0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= 200000) begin
      $display("** point_set_centroid_rotation: FAILED **");
      $finish;
    end
    repeat (20) @(posedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0: return CoordMax;
      1: return CoordMin;
      2: return coord_t'(int'($urandom_range(2000)) - 1000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_trig();
    case ($urandom_range(4))
      0: return 16'd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      default: return 16'($urandom_range(32768)) - 16'd16384;
    endcase
  endfunction

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
  endtask

  initial begin
    int sent;
    int n;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_pt.valid = 1'b0; in_pt.point_x = '0; in_pt.point_y = '0; in_pt.point_z = '0;
    in_pt.last_point = 1'b0;
    rx_noidle = 1'b0; hold_req = 1'b0; noidle = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity rotation: single point, extremes, low-z ceiling miss
    send_point(CoordMax, CoordMin, CoordMax, 1'b1);
    send_point(CoordMin, CoordMax, CoordMin, 1'b0);
    send_point(CoordMax, CoordMin, CoordMax, 1'b1);
    // equal z values check the later-point tie rule
    send_point(24'sd100, 24'sd5, 24'sd7, 1'b0);
    send_point(24'sd200, 24'sd6, 24'sd7, 1'b0);
    send_point(24'sd300, 24'sd9, 24'sd10, 1'b1);
    drain();
    // half-turn about x, quarter-turns about y and z, saturating extremes
    write_reg(RegCosX, -16'sd16384); write_reg(RegSinX, 16'd0);
    write_reg(RegCosY, 16'd0);       write_reg(RegSinY, 16'd16384);
    write_reg(RegCosZ, 16'd0);       write_reg(RegSinZ, -16'sd16384);
    send_point(CoordMax, CoordMax, CoordMax, 1'b0);
    send_point(CoordMin, CoordMin, CoordMin, 1'b1);
    // overfull store: 18 points, the last two dropped
    for (int i = 0; i < 18; i++)
      send_point(rand_coord(), rand_coord(), rand_coord(), i == 17);
    drain();

    sent = 26;
    while (sent < 320) begin
      write_reg(RegCosX, rand_trig()); write_reg(RegSinX, rand_trig());
      write_reg(RegCosY, rand_trig()); write_reg(RegSinY, rand_trig());
      write_reg(RegCosZ, rand_trig()); write_reg(RegSinZ, rand_trig());
      noidle = (sent >= 150 && sent < 230);
      rx_noidle = noidle;
      if (sent > 240) hold_req = 1'b1;
      for (int s = 0; s < 4; s++) begin
        n = ($urandom_range(9) == 0) ? 16 + $urandom_range(2) : 1 + $urandom_range(7);
        send_set(n);
        sent += n;
      end
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("** point_set_centroid_rotation: PASSED **");
    end else begin
      $display("** point_set_centroid_rotation: FAILED **");
    end
    $finish;
  end
endmodule
